@@ src/oukl_pkg.sv @@
// Shared types, constants and helpers of the ordered unique key list.
package oukl_pkg;

  localparam int unsigned Capacity = 32;
  localparam int unsigned KeyBits  = 32;
  localparam int unsigned IdxW     = $clog2(Capacity);
  localparam int unsigned CntW     = $clog2(Capacity + 1);

  typedef logic [KeyBits-1:0] key_t;
  typedef logic [IdxW-1:0]    idx_t;
  typedef logic [CntW-1:0]    cnt_t;

  typedef enum logic [1:0] {
    OpInsert = 2'd0,
    OpRemove = 2'd1,
    OpList   = 2'd2,
    OpNone   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    StInserted  = 3'd0,
    StDuplicate = 3'd1,
    StRemoved   = 3'd2,
    StNotFound  = 3'd3,
    StFull      = 3'd4,
    StListEntry = 3'd5,
    StListEmpty = 3'd6
  } status_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] key;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] entry_key;
    logic [4:0]  position;
    logic        last;
  } rsp_t;

  // Control that the sequencer broadcasts to every cell of the chain.
  typedef struct packed {
    logic rotate;
    logic load;
    logic compact;
    idx_t tgt;
    key_t key;
  } cell_ctl_t;

  function automatic key_t to_key(logic [31:0] k);
    logic [63:0] w;
    w = 64'(k);
    return w[KeyBits-1:0];
  endfunction

  function automatic logic [31:0] to_field(key_t k);
    logic [63:0] w;
    w = 64'(k);
    return w[31:0];
  endfunction

endpackage

@@ src/oukl_cell.sv @@
// One storage cell of the key chain: holds a key, takes its neighbor's on a shift and loads a new key when targeted.
module oukl_cell (
  input  logic                 clk_i,
  input  oukl_pkg::cell_ctl_t  ctl_i,
  input  oukl_pkg::idx_t       idx_i,
  input  oukl_pkg::key_t       nbr_i,
  output oukl_pkg::key_t       key_o
);

  oukl_pkg::key_t key_q, key_d;

  always_comb begin
    key_d = key_q;
    if (ctl_i.rotate) begin
      key_d = nbr_i;
    end else if (ctl_i.load && (idx_i == ctl_i.tgt)) begin
      key_d = ctl_i.key;
    end else if (ctl_i.compact && (idx_i >= ctl_i.tgt)) begin
      // Cells at and above the removed slot pull the next key down.
      key_d = nbr_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o = key_q;

endmodule

@@ src/oukl_ctrl.sv @@
// Sequencer: watches the head of the rotating chain and forms the results.
module oukl_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  oukl_pkg::req_t      req_i,
  output logic                busy,
  input  oukl_pkg::key_t      head_key_i,
  output oukl_pkg::cell_ctl_t ctl_o,
  output oukl_pkg::rsp_t      rsp_o,
  output logic                rsp_valid_o
);

  typedef enum logic [2:0] {
    StIdle   = 3'b001,
    StScan   = 3'b010,
    StFinish = 3'b100
  } state_e;

  state_e            state_q, state_d;
  oukl_pkg::op_e     op_q, op_d;
  oukl_pkg::key_t    key_q, key_d;
  oukl_pkg::idx_t    step_q, step_d;
  logic              found_q, found_d;
  oukl_pkg::idx_t    fidx_q, fidx_d;
  oukl_pkg::cnt_t    count_q, count_d;
  oukl_pkg::rsp_t    rsp_q, rsp_d;
  logic              valid_q, valid_d;
  logic              in_use;

  assign in_use = oukl_pkg::CntW'(step_q) < count_q;

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    key_d   = key_q;
    step_d  = step_q;
    found_d = found_q;
    fidx_d  = fidx_q;
    count_d = count_q;
    rsp_d   = rsp_q;
    valid_d = 1'b0;
    ctl_o.rotate  = 1'b0;
    ctl_o.load    = 1'b0;
    ctl_o.compact = 1'b0;
    ctl_o.tgt     = count_q[oukl_pkg::IdxW-1:0];
    ctl_o.key     = key_q;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          if ((oukl_pkg::op_e'(req_i.op) == oukl_pkg::OpList) && (count_q == '0)) begin
            valid_d         = 1'b1;
            rsp_d.status    = oukl_pkg::StListEmpty;
            rsp_d.entry_key = '0;
            rsp_d.position  = '0;
            rsp_d.last      = 1'b1;
          end else if (oukl_pkg::op_e'(req_i.op) != oukl_pkg::OpNone) begin
            state_d = StScan;
            op_d    = oukl_pkg::op_e'(req_i.op);
            key_d   = oukl_pkg::to_key(req_i.key);
            step_d  = '0;
            found_d = 1'b0;
          end
        end
      end
      StScan: begin
        // One full turn of the chain brings every slot past the head in order
        // and leaves the contents where they started.
        ctl_o.rotate = 1'b1;
        if (op_q == oukl_pkg::OpList) begin
          if (in_use) begin
            valid_d         = 1'b1;
            rsp_d.status    = oukl_pkg::StListEntry;
            rsp_d.entry_key = oukl_pkg::to_field(head_key_i);
            rsp_d.position  = 5'(step_q);
            rsp_d.last      = (oukl_pkg::CntW'(step_q) + oukl_pkg::CntW'(1)) == count_q;
          end
        end else if (in_use && (head_key_i == key_q)) begin
          found_d = 1'b1;
          fidx_d  = step_q;
        end
        if (step_q == oukl_pkg::IdxW'(oukl_pkg::Capacity - 1)) begin
          state_d = StFinish;
        end else begin
          step_d = step_q + oukl_pkg::IdxW'(1);
        end
      end
      StFinish: begin
        state_d         = StIdle;
        rsp_d.entry_key = oukl_pkg::to_field(key_q);
        rsp_d.last      = 1'b1;
        rsp_d.position  = '0;
        if (op_q == oukl_pkg::OpInsert) begin
          valid_d = 1'b1;
          if (found_q) begin
            rsp_d.status   = oukl_pkg::StDuplicate;
            rsp_d.position = 5'(fidx_q);
          end else if (count_q == oukl_pkg::CntW'(oukl_pkg::Capacity)) begin
            rsp_d.status = oukl_pkg::StFull;
          end else begin
            ctl_o.load     = 1'b1;
            rsp_d.status   = oukl_pkg::StInserted;
            rsp_d.position = 5'(count_q);
            count_d        = count_q + oukl_pkg::CntW'(1);
          end
        end else if (op_q == oukl_pkg::OpRemove) begin
          valid_d = 1'b1;
          if (found_q) begin
            ctl_o.compact  = 1'b1;
            ctl_o.tgt      = fidx_q;
            rsp_d.status   = oukl_pkg::StRemoved;
            rsp_d.position = 5'(fidx_q);
            count_d        = count_q - oukl_pkg::CntW'(1);
          end else begin
            rsp_d.status = oukl_pkg::StNotFound;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      valid_q <= 1'b0;
      step_q  <= '0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      valid_q <= valid_d;
      step_q  <= step_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    key_q  <= key_d;
    fidx_q <= fidx_d;
    rsp_q  <= rsp_d;
  end

  assign busy        = (state_q != StIdle);
  assign rsp_o       = rsp_q;
  assign rsp_valid_o = valid_q;

endmodule

@@ src/ordered_unique_key_list_top.sv @@
// Top level of the ordered unique key list: sequencer plus a ring of key cells.
//
// A request is taken at a rising edge with start high and busy low. Its op
// selects insert, remove or list; the key is ignored for list and op 3 is
// dropped without a result. Results come out on rsp_o, each shown for one
// cycle with rsp_valid_o high; the receiver cannot stall them, and the final
// result of a request carries last.
// Insert and remove turn the cell ring once while the head key is compared,
// then append or compact the ring in the finish state; the result shows in
// the same cycle that busy clears, so no new request is taken before then.
// A list request streams stored keys in order, one per cycle, and also
// keeps busy through the whole turn of the ring and the finish state.
// A list request on an empty list answers the next cycle and busy stays low.
// Reset empties the list; stored keys are not cleared, since the count alone
// decides which slots hold keys.
module ordered_unique_key_list_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  oukl_pkg::req_t req_i,
  output logic           busy,
  output oukl_pkg::rsp_t rsp_o,
  output logic           rsp_valid_o
);

  oukl_pkg::cell_ctl_t ctl;
  oukl_pkg::key_t      cell_key [oukl_pkg::Capacity];

  oukl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .req_i       (req_i),
    .busy        (busy),
    .head_key_i  (cell_key[0]),
    .ctl_o       (ctl),
    .rsp_o       (rsp_o),
    .rsp_valid_o (rsp_valid_o)
  );

  for (genvar i = 0; i < oukl_pkg::Capacity; i++) begin : g_cell
    oukl_cell u_cell (
      .clk_i (clk_i),
      .ctl_i (ctl),
      .idx_i (oukl_pkg::IdxW'(i)),
      .nbr_i (cell_key[(i + 1) % oukl_pkg::Capacity]),
      .key_o (cell_key[i])
    );
  end

endmodule

@@ src/oukl_checker.sv @@
// Port-level checks of the ordered unique key list, bound to the top level.
module oukl_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input oukl_pkg::req_t req_i,
  input logic           busy,
  input oukl_pkg::rsp_t rsp_o,
  input logic           rsp_valid_o
);

  // A result that follows an idle cycle can only be the empty-list answer.
  a_idle_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !$past(busy) |->
      (rsp_o.status == oukl_pkg::StListEmpty) && rsp_o.last)
    else $error("result after idle cycle is not an empty-list answer");

  // Insert and remove requests give a single result.
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && (rsp_o.status != oukl_pkg::StListEntry) |-> rsp_o.last)
    else $error("single result without last");

  a_empty_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && (rsp_o.status == oukl_pkg::StListEmpty) |->
      (rsp_o.entry_key == '0) && (rsp_o.position == '0))
    else $error("empty-list answer with nonzero fields");

  // An accepted insert or remove occupies the block for its scan.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && ((req_i.op == oukl_pkg::OpInsert) || (req_i.op == oukl_pkg::OpRemove))
      |=> busy)
    else $error("insert or remove request did not raise busy");

endmodule

bind ordered_unique_key_list_top oukl_checker u_oukl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .req_i       (req_i),
  .busy        (busy),
  .rsp_o       (rsp_o),
  .rsp_valid_o (rsp_valid_o)
);
